FILE: rtl/vlt_pkg.sv
// ----------------------------------------------------------------------------
// vlt_pkg
// shared types, constants and codes of the velocity limiter with timeout
// ----------------------------------------------------------------------------
package vlt_pkg;

   // field and register widths
   localparam int DATA_WIDTH      = 16;
   localparam int FRAC_BITS       = 12;
   localparam int LIM_WIDTH       = 15;
   localparam int TMO_WIDTH       = 16;
   localparam int STAMP_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // register reset values
   localparam logic [LIM_WIDTH-1:0] MAX_LINEAR_RESET  = LIM_WIDTH'(1 << FRAC_BITS);
   localparam logic [LIM_WIDTH-1:0] MAX_ANGULAR_RESET = LIM_WIDTH'(2 << FRAC_BITS);
   localparam logic [TMO_WIDTH-1:0] TIMEOUT_RESET     = TMO_WIDTH'(500);

   // iteration lengths of the shared unit
   localparam int SQRT_STEPS = 16;
   localparam int DIV_STEPS  = 15;
   localparam int CNT_WIDTH  = 4;

   // function codes of an input word
   localparam logic FUNC_CMD   = 1'b0;
   localparam logic FUNC_CHECK = 1'b1;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_APPLY = 2'd1,
      ACT_STOP  = 2'd2
   } action_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAX_LINEAR  = 2'd0,
      CSR_MAX_ANGULAR = 2'd1,
      CSR_TIMEOUT     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                         func;
      logic [STAMP_WIDTH-1:0]       now_ms;
      logic signed [DATA_WIDTH-1:0] vx;
      logic signed [DATA_WIDTH-1:0] vy;
      logic signed [DATA_WIDTH-1:0] wz;
   } req_type;

   typedef struct packed {
      action_type                   action;
      logic signed [DATA_WIDTH-1:0] vx_out;
      logic signed [DATA_WIDTH-1:0] vy_out;
      logic signed [DATA_WIDTH-1:0] wz_out;
      logic                         linear_limited;
      logic                         warn;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_LIM,
      ST_CMP,
      ST_SQRT,
      ST_MUL_X,
      ST_DIV_X,
      ST_MUL_Y,
      ST_DIV_Y,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQ_LIM,
      OP_CMP,
      OP_SQRT,
      OP_MUL_X,
      OP_DIV_X,
      OP_MUL_Y,
      OP_DIV_Y
   } op_type;

   typedef struct packed {
      op_type op;
      logic   first;
   } ctrl_type;

endpackage

FILE: rtl/vlt_seq.sv
// ----------------------------------------------------------------------------
// vlt_seq
// sequencer that steps the shared multiply and subtract unit
// ----------------------------------------------------------------------------
module vlt_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_func,
   input  logic              over_lim,
   input  logic              out_free,
   output logic              req_ready,
   output logic              rsp_load,
   output vlt_pkg::ctrl_type ctrl
);
   import vlt_pkg::*;

   state_type              state_ff, state_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   start;
   logic                   sqrt_last;
   logic                   div_last;

   assign start     = req_valid && (state_ff == ST_IDLE);
   assign sqrt_last = (cnt_ff == CNT_WIDTH'(SQRT_STEPS - 1));
   assign div_last  = (cnt_ff == CNT_WIDTH'(DIV_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_func == FUNC_CHECK) ? ST_DONE : ST_SQ_X;
            end
         end
         ST_SQ_X:   state_in = ST_SQ_Y;
         ST_SQ_Y:   state_in = ST_SQ_LIM;
         ST_SQ_LIM: state_in = ST_CMP;
         ST_CMP:    state_in = over_lim ? ST_SQRT : ST_DONE;
         ST_SQRT: begin
            if (sqrt_last) begin
               state_in = ST_MUL_X;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MUL_X:  state_in = ST_DIV_X;
         ST_DIV_X: begin
            if (div_last) begin
               state_in = ST_MUL_Y;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MUL_Y:  state_in = ST_DIV_Y;
         ST_DIV_Y: begin
            if (div_last) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      rsp_load   = 1'b0;
      ctrl.op    = OP_NONE;
      ctrl.first = (cnt_ff == '0);
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (start && (req_func == FUNC_CMD)) begin
               ctrl.op = OP_LOAD;
            end
         end
         ST_SQ_X:   ctrl.op = OP_SQ_X;
         ST_SQ_Y:   ctrl.op = OP_SQ_Y;
         ST_SQ_LIM: ctrl.op = OP_SQ_LIM;
         ST_CMP:    ctrl.op = OP_CMP;
         ST_SQRT:   ctrl.op = OP_SQRT;
         ST_MUL_X:  ctrl.op = OP_MUL_X;
         ST_DIV_X:  ctrl.op = OP_DIV_X;
         ST_MUL_Y:  ctrl.op = OP_MUL_Y;
         ST_DIV_Y:  ctrl.op = OP_DIV_Y;
         ST_DONE:   rsp_load = out_free;
         default:   ctrl.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: rtl/vlt_dpath.sv
// ----------------------------------------------------------------------------
// vlt_dpath
// working registers around one multiplier and one subtractor
// ----------------------------------------------------------------------------
module vlt_dpath (
   input  logic                                      clock,
   input  vlt_pkg::ctrl_type                         ctrl,
   input  vlt_pkg::req_type                          req_data,
   input  logic [vlt_pkg::LIM_WIDTH-1:0]             max_linear,
   input  logic [vlt_pkg::LIM_WIDTH-1:0]             max_angular,
   output logic                                      over_lim,
   output logic signed [vlt_pkg::DATA_WIDTH-1:0]     vx_res,
   output logic signed [vlt_pkg::DATA_WIDTH-1:0]     vy_res,
   output logic signed [vlt_pkg::DATA_WIDTH-1:0]     wz_res,
   output logic                                      lim_flag
);
   import vlt_pkg::*;

   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int REM_WIDTH  = DATA_WIDTH + 2;
   localparam int QUO_WIDTH  = LIM_WIDTH;

   logic signed [DATA_WIDTH-1:0] vx_ff, vx_in, vy_ff, vy_in, wz_ff, wz_in;
   logic [PROD_WIDTH-1:0]        prod_ff, prod_in, acc_ff, acc_in;
   logic [REM_WIDTH-1:0]         rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]        root_ff, root_in;
   logic [QUO_WIDTH-1:0]         quo_ff, quo_in, qx_ff, qx_in;
   logic                         lim_flag_ff, lim_flag_in;

   logic [DATA_WIDTH-1:0]        ax, ay, lim;
   logic [DATA_WIDTH-1:0]        mul_a, mul_b;
   logic [PROD_WIDTH-1:0]        mul_p;
   logic [REM_WIDTH-1:0]         sub_a, sub_b;
   logic [REM_WIDTH:0]           sub_d;
   logic                         ge;
   logic signed [DATA_WIDTH-1:0] sx, sy;

   function automatic logic [DATA_WIDTH-1:0] abs_val(input logic [DATA_WIDTH-1:0] v);
      return v[DATA_WIDTH-1] ? (~v + DATA_WIDTH'(1)) : v;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] clamp_sym(
      input logic signed [DATA_WIDTH-1:0] v,
      input logic [LIM_WIDTH-1:0]         l
   );
      logic signed [DATA_WIDTH:0] v_w;
      logic signed [DATA_WIDTH:0] l_w;
      v_w = $signed({v[DATA_WIDTH-1], v});
      l_w = $signed({{(DATA_WIDTH + 1 - LIM_WIDTH){1'b0}}, l});
      if (v_w > l_w) begin
         return l_w[DATA_WIDTH-1:0];
      end else if (v_w < -l_w) begin
         return DATA_WIDTH'(-l_w);
      end
      return v;
   endfunction

   assign ax  = abs_val(vx_ff);
   assign ay  = abs_val(vy_ff);
   assign lim = {{(DATA_WIDTH - LIM_WIDTH){1'b0}}, max_linear};

   // shared multiplier operand select
   always_comb begin
      mul_a = lim;
      mul_b = lim;
      case (ctrl.op)
         OP_SQ_X:  begin mul_a = ax; mul_b = ax; end
         OP_SQ_Y:  begin mul_a = ay; mul_b = ay; end
         OP_MUL_X: mul_a = ax;
         OP_MUL_Y: mul_a = ay;
         default:  mul_a = lim;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // shared subtractor: square root digit or divide step
   always_comb begin
      if (ctrl.op == OP_SQRT) begin
         sub_a = {rem_ff[DATA_WIDTH-1:0], acc_ff[PROD_WIDTH-1 -: 2]};
         sub_b = {root_ff, 2'b01};
      end else begin
         sub_a = ctrl.first ? {2'b00, prod_ff[2*LIM_WIDTH-1 -: DATA_WIDTH]}
                            : {rem_ff[REM_WIDTH-2:0], acc_ff[PROD_WIDTH-1]};
         sub_b = {2'b00, root_ff};
      end
   end

   assign sub_d    = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge       = ~sub_d[REM_WIDTH];
   assign over_lim = (acc_ff > prod_ff);

   always_comb begin
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      wz_in       = wz_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      quo_in      = quo_ff;
      qx_in       = qx_ff;
      lim_flag_in = lim_flag_ff;
      case (ctrl.op) inside
         OP_LOAD: begin
            vx_in       = req_data.vx;
            vy_in       = req_data.vy;
            wz_in       = req_data.wz;
            lim_flag_in = 1'b0;
         end
         OP_SQ_X: prod_in = mul_p;
         OP_SQ_Y: begin
            prod_in = mul_p;
            acc_in  = prod_ff;
         end
         OP_SQ_LIM: begin
            prod_in = mul_p;
            acc_in  = acc_ff + prod_ff;
         end
         OP_CMP: begin
            lim_flag_in = over_lim;
            rem_in      = '0;
            root_in     = '0;
         end
         OP_SQRT: begin
            rem_in  = ge ? sub_d[REM_WIDTH-1:0] : sub_a;
            root_in = {root_ff[DATA_WIDTH-2:0], ge};
            acc_in  = {acc_ff[PROD_WIDTH-3:0], 2'b00};
         end
         OP_MUL_X: prod_in = mul_p;
         OP_MUL_Y: begin
            prod_in = mul_p;
            qx_in   = quo_ff;
         end
         OP_DIV_X, OP_DIV_Y: begin
            rem_in = ge ? sub_d[REM_WIDTH-1:0] : sub_a;
            quo_in = {quo_ff[QUO_WIDTH-2:0], ge};
            acc_in = ctrl.first ? {prod_ff[QUO_WIDTH-2:0], {(PROD_WIDTH-QUO_WIDTH+1){1'b0}}}
                                : {acc_ff[PROD_WIDTH-2:0], 1'b0};
         end
         default: lim_flag_in = lim_flag_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      wz_ff       <= wz_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      quo_ff      <= quo_in;
      qx_ff       <= qx_in;
      lim_flag_ff <= lim_flag_in;
   end

   // scaled magnitudes take the sign of the command back
   always_comb begin
      sx = vx_ff;
      sy = vy_ff;
      if (lim_flag_ff) begin
         sx = vx_ff[DATA_WIDTH-1] ? -$signed({1'b0, qx_ff}) : $signed({1'b0, qx_ff});
         sy = vy_ff[DATA_WIDTH-1] ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      end
   end

   assign vx_res   = clamp_sym(sx, max_linear);
   assign vy_res   = clamp_sym(sy, max_linear);
   assign wz_res   = clamp_sym(wz_ff, max_angular);
   assign lim_flag = lim_flag_ff;

endmodule

FILE: rtl/velocity_limiter_with_timeout_core.sv
// ----------------------------------------------------------------------------
// velocity_limiter_with_timeout_core
// velocity command limiter with a command watchdog
// ----------------------------------------------------------------------------
// each input word is a velocity command or a watchdog check and yields exactly
// one result word. an accepted command runs through the shared multiplier
// and subtractor: three squarings, one compare, and, when the vector is over
// the linear limit, a 16-step floor square root and two 15-step restoring
// divides. a check word goes straight to the result, and a command within the
// limit skips the square root and divides, so a limited command takes longest.
// a finished result waits until the output register is free; once it is
// loaded there, a new word is accepted while it waits to be taken.
// configuration writes are registered directly from the csr port.
module velocity_limiter_with_timeout_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  vlt_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output vlt_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_we,
   input  logic [vlt_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [vlt_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import vlt_pkg::*;

   // configuration registers
   logic [LIM_WIDTH-1:0]   max_linear_ff, max_linear_in;
   logic [LIM_WIDTH-1:0]   max_angular_ff, max_angular_in;
   logic [TMO_WIDTH-1:0]   timeout_ff, timeout_in;

   // watchdog state
   logic [STAMP_WIDTH-1:0] last_stamp_ff, last_stamp_in;
   logic                   warned_ff, warned_in;

   // pending word kind and check result, held until the result is loaded
   logic                   func_ff, func_in;
   logic                   chk_stop_ff, chk_stop_in;
   logic                   chk_warn_ff, chk_warn_in;

   // output register
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   accept;
   logic                   out_free;
   logic                   rsp_load;
   logic                   over_lim;
   logic                   stop;
   logic [STAMP_WIDTH-1:0] elapsed;
   ctrl_type               ctrl;
   logic signed [DATA_WIDTH-1:0] vx_res, vy_res, wz_res;
   logic                   lim_flag;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   vlt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .over_lim  (over_lim),
      .out_free  (out_free),
      .req_ready (req_ready),
      .rsp_load  (rsp_load),
      .ctrl      (ctrl)
   );

   vlt_dpath u_dpath (
      .clock       (clock),
      .ctrl        (ctrl),
      .req_data    (req_data),
      .max_linear  (max_linear_ff),
      .max_angular (max_angular_ff),
      .over_lim    (over_lim),
      .vx_res      (vx_res),
      .vy_res      (vy_res),
      .wz_res      (wz_res),
      .lim_flag    (lim_flag)
   );

   // csr write decode, writes past the last register are dropped
   always_comb begin
      max_linear_in  = max_linear_ff;
      max_angular_in = max_angular_ff;
      timeout_in     = timeout_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_LINEAR:  max_linear_in  = csr_wdata[LIM_WIDTH-1:0];
            CSR_MAX_ANGULAR: max_angular_in = csr_wdata[LIM_WIDTH-1:0];
            CSR_TIMEOUT:     timeout_in     = csr_wdata[TMO_WIDTH-1:0];
            default:         timeout_in     = timeout_ff;
         endcase
      end
   end

   // watchdog: elapsed time wraps modulo 2^32, a zero stamp means disarmed
   assign elapsed = req_data.now_ms - last_stamp_ff;
   assign stop    = (last_stamp_ff != '0) &&
                    (elapsed > {{(STAMP_WIDTH - TMO_WIDTH){1'b0}}, timeout_ff});

   always_comb begin
      last_stamp_in = last_stamp_ff;
      warned_in     = warned_ff;
      func_in       = func_ff;
      chk_stop_in   = chk_stop_ff;
      chk_warn_in   = chk_warn_ff;
      if (accept) begin
         func_in = req_data.func;
         if (req_data.func == FUNC_CMD) begin
            last_stamp_in = req_data.now_ms;
         end else begin
            chk_stop_in = stop;
            chk_warn_in = stop && !warned_ff;
            warned_in   = warned_ff || stop;
         end
      end
   end

   // result assembly into the output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (func_ff == FUNC_CMD) begin
            rsp_in.action         = ACT_APPLY;
            rsp_in.vx_out         = vx_res;
            rsp_in.vy_out         = vy_res;
            rsp_in.wz_out         = wz_res;
            rsp_in.linear_limited = lim_flag;
            rsp_in.warn           = 1'b0;
         end else begin
            rsp_in.action         = chk_stop_ff ? ACT_STOP : ACT_NONE;
            rsp_in.vx_out         = '0;
            rsp_in.vy_out         = '0;
            rsp_in.wz_out         = '0;
            rsp_in.linear_limited = 1'b0;
            rsp_in.warn           = chk_warn_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_linear_ff  <= MAX_LINEAR_RESET;
         max_angular_ff <= MAX_ANGULAR_RESET;
         timeout_ff     <= TIMEOUT_RESET;
         last_stamp_ff  <= '0;
         warned_ff      <= 1'b0;
         func_ff        <= FUNC_CMD;
         chk_stop_ff    <= 1'b0;
         chk_warn_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_linear_ff  <= max_linear_in;
         max_angular_ff <= max_angular_in;
         timeout_ff     <= timeout_in;
         last_stamp_ff  <= last_stamp_in;
         warned_ff      <= warned_in;
         func_ff        <= func_in;
         chk_stop_ff    <= chk_stop_in;
         chk_warn_ff    <= chk_warn_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // one word at a time: an accepted word keeps the block busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("block ready right after accepting a word");

   // a warning only ever comes with a stop order
   a_warn_is_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.warn |-> rsp_data.action == ACT_STOP)
      else $error("warning without stop order");

   // once warned, never warned again until reset
   a_warned_sticky: assert property (@(posedge clock) disable iff (reset)
      warned_ff |=> warned_ff)
      else $error("warned flag cleared without reset");

   // non-command results carry zero velocity fields
   a_check_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.action != ACT_APPLY) |->
         (rsp_data.vx_out == '0) && (rsp_data.vy_out == '0) &&
         (rsp_data.wz_out == '0) && !rsp_data.linear_limited)
      else $error("check result with nonzero velocity fields");

endmodule

FILE: dv/tb_velocity_limiter_with_timeout_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_velocity_limiter_with_timeout_core
// self-checking bench for the velocity limiter with command watchdog
// ----------------------------------------------------------------------------
// a built-in predictor follows every accepted word: it keeps its own copy of
// the limits, the timeout, the last command stamp and the warned flag, and it
// works out the limited velocity or watchdog verdict for each word. results
// are compared field by field in order. a short directed pass covers the
// limit edges, the watchdog edges, stamp wrap and the register extremes; then
// random traffic runs under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_velocity_limiter_with_timeout_core;
   import vlt_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 12;
   localparam int TAIL_CYCLES = 60;
   localparam int REPORT_LIMIT = 10;

   // ---------------------------------------------------------------- dut io
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   velocity_limiter_with_timeout_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------- shadow state
   // limits and timeout as the block holds them, plus the watchdog memory
   logic [LIM_WIDTH-1:0]   lin_lim_q;
   logic [LIM_WIDTH-1:0]   ang_lim_q;
   logic [TMO_WIDTH-1:0]   tmo_q;
   logic [STAMP_WIDTH-1:0] stamp_q;
   logic                   warned_q;

   // results owed by the block, oldest first
   rsp_type due_rsp_q[$];

   // idle odds in percent of cycles for each side
   int unsigned snd_idle_pct = 0;
   int unsigned rcv_idle_pct = 0;

   // tallies
   int mismatches = 0;
   int n_cmds = 0;
   int n_scaled = 0;
   int n_checks = 0;
   int n_stops = 0;
   int n_warns = 0;

   // stimulus time base: stamp of the last generated command
   logic [STAMP_WIDTH-1:0] gen_ms = '0;

   // ------------------------------------------------------------- predictor
   // floor square root, one result bit at a time from the top
   function automatic logic [63:0] floor_root(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] trial;
      r = '0;
      for (int b = 20; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= x)
            r = trial;
      end
      return r;
   endfunction

   // v * lim / root on magnitudes, truncated toward zero
   function automatic logic signed [63:0] shrink(input logic signed [63:0] v,
                                                 input logic [63:0] lim,
                                                 input logic [63:0] root);
      logic [63:0] m;
      logic [63:0] q;
      m = (v < 0) ? -v : v;
      q = (m * lim) / root;
      return (v < 0) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] clip_sym(input logic signed [63:0] v,
                                                             input logic signed [63:0] bound);
      if (v > bound)
         return DATA_WIDTH'(bound);
      if (v < -bound)
         return DATA_WIDTH'(-bound);
      return DATA_WIDTH'(v);
   endfunction

   // result of one word; advances the watchdog memory as the block does
   function automatic rsp_type limit_velocity(input req_type w);
      rsp_type                r;
      logic signed [63:0]     sx;
      logic signed [63:0]     sy;
      logic [63:0]            ax;
      logic [63:0]            ay;
      logic [63:0]            sumsq;
      logic [63:0]            lim;
      logic [63:0]            root;
      logic [STAMP_WIDTH-1:0] elapsed;
      r = '0;
      r.action = ACT_NONE;
      if (w.func == FUNC_CMD) begin
         sx = $signed(w.vx);
         sy = $signed(w.vy);
         ax = (sx < 0) ? -sx : sx;
         ay = (sy < 0) ? -sy : sy;
         sumsq = ax * ax + ay * ay;
         lim = {49'd0, lin_lim_q};
         stamp_q = w.now_ms;
         // scale only when strictly outside the circle
         if (sumsq > lim * lim) begin
            root = floor_root(sumsq);
            sx = shrink(sx, lim, root);
            sy = shrink(sy, lim, root);
            r.linear_limited = 1'b1;
            n_scaled++;
         end
         r.vx_out = clip_sym(sx, $signed(lim));
         r.vy_out = clip_sym(sy, $signed(lim));
         r.wz_out = clip_sym($signed(w.wz), $signed({49'd0, ang_lim_q}));
         r.action = ACT_APPLY;
         n_cmds++;
      end else begin
         n_checks++;
         elapsed = w.now_ms - stamp_q;
         // a zero stamp means no command yet, watchdog disarmed
         if (stamp_q != '0 && elapsed > {16'd0, tmo_q}) begin
            r.action = ACT_STOP;
            n_stops++;
            if (!warned_q) begin
               r.warn = 1'b1;
               warned_q = 1'b1;
               n_warns++;
            end
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------- result check
   task automatic flag_field(input string fld, input longint want, input longint got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, fld, want, got);
   endtask

   task automatic compare_rsp(input rsp_type got, input rsp_type want);
      if (got.action !== want.action)
         flag_field("action", longint'(want.action), longint'(got.action));
      if (got.vx_out !== want.vx_out)
         flag_field("vx_out", longint'(want.vx_out), longint'(got.vx_out));
      if (got.vy_out !== want.vy_out)
         flag_field("vy_out", longint'(want.vy_out), longint'(got.vy_out));
      if (got.wz_out !== want.wz_out)
         flag_field("wz_out", longint'(want.wz_out), longint'(got.wz_out));
      if (got.linear_limited !== want.linear_limited)
         flag_field("linear_limited", longint'(want.linear_limited),
                    longint'(got.linear_limited));
      if (got.warn !== want.warn)
         flag_field("warn", longint'(want.warn), longint'(got.warn));
   endtask

   // receiver: random back-pressure and in-order checking of every word taken
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result word with nothing expected, action %0d",
                        $realtime, rsp_data.action);
         end else begin
            compare_rsp(rsp_data, due_rsp_q.pop_front());
         end
      end
   end

   // --------------------------------------------------------------- drivers
   function automatic req_type mk_word(input logic func, input logic [31:0] now,
                                       input int vx, input int vy, input int wz);
      req_type w;
      w.func = func;
      w.now_ms = now;
      w.vx = DATA_WIDTH'(vx);
      w.vy = DATA_WIDTH'(vy);
      w.wz = DATA_WIDTH'(wz);
      return w;
   endfunction

   // send one word; valid stays up after the accept so words can go back to
   // back, settle_idle drops it at the end of a batch
   task automatic send_word(input req_type w);
      int gap;
      gap = 0;
      while ($urandom_range(99) < snd_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      due_rsp_q.push_back(limit_velocity(w));
   endtask

   // drop valid and wait until every owed result has been taken
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (due_rsp_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, only called with the block idle
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MAX_LINEAR:  lin_lim_q = val[LIM_WIDTH-1:0];
         CSR_MAX_ANGULAR: ang_lim_q = val[LIM_WIDTH-1:0];
         default:         tmo_q = val[TMO_WIDTH-1:0];
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_limits(input int lin, input int ang, input int tmo);
      write_csr(CSR_MAX_LINEAR, CSR_DATA_WIDTH'(lin));
      write_csr(CSR_MAX_ANGULAR, CSR_DATA_WIDTH'(ang));
      write_csr(CSR_TIMEOUT, CSR_DATA_WIDTH'(tmo));
   endtask

   // ----------------------------------------------------- random generation
   // a speed from one of several regions: anywhere, near a bound, the
   // corners of the range, or small
   function automatic logic signed [DATA_WIDTH-1:0] pick_speed(input int bound);
      int v;
      case ($urandom_range(3))
         0: v = int'($urandom_range(65535)) - 32768;
         1: v = int'($urandom_range(2 * bound + 4)) - bound - 2;
         2: begin
            case ($urandom_range(4))
               0:       v = -32768;
               1:       v = 32767;
               2:       v = 0;
               3:       v = -1;
               default: v = 1;
            endcase
         end
         default: v = int'($urandom_range(1024)) - 512;
      endcase
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return DATA_WIDTH'(v);
   endfunction

   function automatic req_type random_word();
      req_type     w;
      logic [31:0] span;
      w.vx = pick_speed(int'(lin_lim_q));
      w.vy = pick_speed(int'(lin_lim_q));
      w.wz = pick_speed(int'(ang_lim_q));
      if ($urandom_range(99) < 45) begin
         // check words land mostly around the timeout edge
         w.func = FUNC_CHECK;
         case ($urandom_range(5))
            0:       span = {16'd0, tmo_q} - 32'd1;
            1:       span = {16'd0, tmo_q};
            2:       span = {16'd0, tmo_q} + 32'd1;
            3:       span = $urandom();
            default: span = $urandom_range(2 * int'(tmo_q) + 2);
         endcase
         w.now_ms = gen_ms + span;
      end else begin
         w.func = FUNC_CMD;
         case ($urandom_range(19))
            0:       gen_ms = '0;                // disarms the watchdog
            1:       gen_ms = $urandom();
            2:       gen_ms = 32'hFFFF_FFFF - $urandom_range(600);
            default: gen_ms = gen_ms + $urandom_range(int'(tmo_q) / 2 + 2, 1);
         endcase
         w.now_ms = gen_ms;
      end
      return w;
   endfunction

   function automatic int pick_limit();
      case ($urandom_range(4))
         0:       return 0;
         1:       return 32767;
         2:       return 4096;
         3:       return $urandom_range(256, 1);
         default: return $urandom_range(32767);
      endcase
   endfunction

   function automatic int pick_timeout();
      case ($urandom_range(4))
         0:       return 0;
         1:       return 65535;
         2:       return 500;
         3:       return $urandom_range(50, 1);
         default: return $urandom_range(65535);
      endcase
   endfunction

   // ------------------------------------------------------------ test tasks
   // watchdog at reset settings: disarmed start, zero stamp, the edge at
   // exactly the timeout, first stop warns, repeated stops, stamp wrap
   task automatic test_watchdog_basics();
      send_word(mk_word(FUNC_CHECK, 32'hFFFF_FFFF, 0, 0, 0));
      send_word(mk_word(FUNC_CMD, 32'd0, 0, 0, 0));
      send_word(mk_word(FUNC_CHECK, 32'd12345, 0, 0, 0));
      send_word(mk_word(FUNC_CMD, 32'd100, 2048, -2048, 4096));
      send_word(mk_word(FUNC_CHECK, 32'd600, 0, 0, 0));
      send_word(mk_word(FUNC_CHECK, 32'd601, 0, 0, 0));
      send_word(mk_word(FUNC_CHECK, 32'd5000, 0, 0, 0));
      send_word(mk_word(FUNC_CMD, 32'hFFFF_FF00, 4096, 0, -8192));
      send_word(mk_word(FUNC_CHECK, 32'h0000_00F3, 0, 0, 0));
      send_word(mk_word(FUNC_CHECK, 32'h0000_01F5, 0, 0, 0));
   endtask

   // linear scaling at reset limits: range corners, just over the circle,
   // a diagonal just outside, and tiny negatives
   task automatic test_limiter_edges();
      send_word(mk_word(FUNC_CMD, 32'd200, 32767, -32768, -32768));
      send_word(mk_word(FUNC_CMD, 32'd201, -4097, 0, 32767));
      send_word(mk_word(FUNC_CMD, 32'd202, 3000, 3000, 0));
      send_word(mk_word(FUNC_CMD, 32'd203, -1, -1, -1));
   endtask

   // every register at both ends: zero limits and zero timeout, then full
   task automatic test_register_extremes();
      settle_idle();
      load_limits(0, 0, 0);
      send_word(mk_word(FUNC_CMD, 32'd7, 1, 0, 5));
      send_word(mk_word(FUNC_CMD, 32'd7, 0, 0, 0));
      send_word(mk_word(FUNC_CHECK, 32'd7, 0, 0, 0));
      send_word(mk_word(FUNC_CHECK, 32'd8, 0, 0, 0));
      settle_idle();
      load_limits(32767, 32767, 65535);
      send_word(mk_word(FUNC_CMD, 32'd1000, -32768, -32768, -32768));
      send_word(mk_word(FUNC_CMD, 32'd1000, 32767, 0, 32767));
      send_word(mk_word(FUNC_CHECK, 32'd66535, 0, 0, 0));
      send_word(mk_word(FUNC_CHECK, 32'd66536, 0, 0, 0));
      settle_idle();
      load_limits(int'(MAX_LINEAR_RESET), int'(MAX_ANGULAR_RESET), int'(TIMEOUT_RESET));
   endtask

   // random words under a fresh register setting and the given idle odds
   task automatic test_random_traffic(input int n_words, input int unsigned snd_pct,
                                      input int unsigned rcv_pct);
      settle_idle();
      load_limits(pick_limit(), pick_limit(), pick_timeout());
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      repeat (n_words)
         send_word(random_word());
   endtask

   // -------------------------------------------------------------- sequence
   initial begin
      lin_lim_q = MAX_LINEAR_RESET;
      ang_lim_q = MAX_ANGULAR_RESET;
      tmo_q     = TIMEOUT_RESET;
      stamp_q   = '0;
      warned_q  = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed part runs with both sides stalling
      snd_idle_pct = 37;
      rcv_idle_pct = 49;
      test_watchdog_basics();
      test_limiter_edges();
      test_register_extremes();

      // random part: receiver-heavy idling, sender-heavy, then none
      test_random_traffic(185, 37, 49);
      test_random_traffic(185, 37, 49);
      test_random_traffic(185, 49, 37);
      test_random_traffic(185, 49, 37);
      test_random_traffic(180, 0, 0);
      test_random_traffic(180, 0, 0);

      settle_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (due_rsp_q.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", due_rsp_q.size());
      end
      $display("covered %0d commands (%0d scaled) and %0d watchdog checks",
               n_cmds, n_scaled, n_checks);
      $display("watchdog stops %0d, warnings %0d, mismatches %0d",
               n_stops, n_warns, mismatches);
      if (mismatches == 0)
         $display("tb_velocity_limiter_with_timeout_core: done, clean");
      else
         $display("tb_velocity_limiter_with_timeout_core: done, errors");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #25_000_000;
      $display("timeout with %0d results outstanding", due_rsp_q.size());
      $display("tb_velocity_limiter_with_timeout_core: done, errors");
      $finish;
   end

endmodule

FILE: files.f
rtl/vlt_pkg.sv
rtl/vlt_seq.sv
rtl/vlt_dpath.sv
rtl/velocity_limiter_with_timeout_core.sv
dv/tb_velocity_limiter_with_timeout_core.sv
